>>> design/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Types and codes shared by the sorted value table and its storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package svt_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_SEARCH = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] entry_count;
    } out_item_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic               ins_en;
        logic               del_en;
        logic signed [31:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/svt_cell.sv
// ----------------------------------------------------------------------------
// svt_cell
// One slot of the sorted chain: compares its entry with the broadcast key
// and on an insert takes from its left neighbor, on a delete from its right.
// ----------------------------------------------------------------------------
`default_nettype none

module svt_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic               clk,
    input  wire svt_pkg::cell_ctrl_t ctrl,
    input  wire logic [CW-1:0]      count,
    input  wire logic               left_le,
    input  wire logic signed [31:0] left_value,
    input  wire logic signed [31:0] right_value,
    output logic                    le,
    output logic                    eq,
    output logic signed [31:0]      value
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               occ;
    logic               lt;

    // A slot holds a live value only below the fill count.
    assign occ   = CW'(IDX) < count;
    assign le    = occ && (entry_reg <= ctrl.key);
    assign lt    = occ && (entry_reg < ctrl.key);
    assign eq    = occ && (entry_reg == ctrl.key);
    assign value = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (!le)
            begin
                // The first slot past the run of smaller-or-equal values gets
                // the key; every slot after it shifts right by one.
                entry_next = left_le ? ctrl.key : left_value;
            end
        end
        else if (ctrl.del_en)
        begin
            if (!lt)
            begin
                entry_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

>>> design/sorted_value_table.sv
// Flow: an accepted input waits in the command register, which feeds the chain;
// the result register loads when that command fires, held off while a result stalls.
// Throughput: one item per cycle while the output does not stall; every cell
// of the chain compares against the key and shifts in the same cycle.
// Reset: rst_n clears the fill count and both valid flags at once; entry
// storage is not cleared, slots above the fill count are never read.
// ----------------------------------------------------------------------------
// sorted_value_table
// Ascending table of signed values built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_value_table #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire svt_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output svt_pkg::out_item_t      out_data
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic              cmd_valid_reg;
    svt_pkg::in_item_t cmd_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              out_valid_reg;
    svt_pkg::out_item_t out_reg;
    logic [2:0]        status;
    logic              fire;
    logic              not_full;
    logic              hit;
    logic [CW+4:0]     count_ext;
    svt_pkg::cell_ctrl_t ctrl;

    logic               le_vec  [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;
    logic signed [31:0] val_vec [CAPACITY];

    assign fire     = cmd_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !cmd_valid_reg || fire;
    assign not_full = count_reg < CW'(CAPACITY);
    assign hit      = |eq_vec;

    assign ctrl.key    = cmd_reg.value;
    assign ctrl.ins_en = fire && (cmd_reg.action == svt_pkg::ACT_INSERT) && not_full;
    assign ctrl.del_en = fire && (cmd_reg.action == svt_pkg::ACT_DELETE) && hit;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic               left_le;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_le    = 1'b1;
            assign left_value = cmd_reg.value;
        end
        else
        begin : g_mid
            assign left_le    = le_vec[i-1];
            assign left_value = val_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cmd_reg.value;
        end
        else
        begin : g_inner
            assign right_value = val_vec[i+1];
        end

        svt_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_le     (left_le),
            .left_value  (left_value),
            .right_value (right_value),
            .le          (le_vec[i]),
            .eq          (eq_vec[i]),
            .value       (val_vec[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        status     = svt_pkg::ST_NOT_FOUND;
        unique case (cmd_reg.action)
            svt_pkg::ACT_INSERT:
            begin
                if (not_full)
                begin
                    count_next = count_reg + CW'(1);
                    status     = svt_pkg::ST_INSERTED;
                end
                else
                begin
                    status = svt_pkg::ST_FULL;
                end
            end
            svt_pkg::ACT_SEARCH:
            begin
                status = hit ? svt_pkg::ST_FOUND : svt_pkg::ST_NOT_FOUND;
            end
            svt_pkg::ACT_DELETE:
            begin
                if (hit)
                begin
                    count_next = count_reg - CW'(1);
                    status     = svt_pkg::ST_REMOVED;
                end
            end
            svt_pkg::ACT_CLEAR:
            begin
                count_next = '0;
                status     = svt_pkg::ST_CLEARED;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    assign count_ext = {5'b0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                cmd_valid_reg <= in_valid;
            end
            if (fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_data;
        end
        if (fire)
        begin
            out_reg.status      <= status;
            out_reg.entry_count <= count_ext[4:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A full report is given only when the table really was full.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (status == svt_pkg::ST_FULL) |-> count_reg == CW'(CAPACITY))
        else $error("full status with free slots");

    // A successful insert grows the table by exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the table by one");

    // A command cannot retire while the previous result is still stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !fire)
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire
